// ===== rtl/lzss_pkg.sv =====
// ----------------------------------------------------------------------------
// lzss_pkg
// Shared types and constants of the LZSS stream decoder: ring geometry,
// request and status codes, controller states and the ring access request.
// ----------------------------------------------------------------------------
package lzss_pkg;

  // History ring geometry
  localparam int unsigned RingSize = 4096;
  localparam int unsigned RingAw   = 12;
  localparam int unsigned MaxMatch = 18;
  localparam int unsigned MinMatch = 3;

  localparam logic [RingAw-1:0] StartPos = RingAw'(RingSize - MaxMatch);
  localparam logic [RingAw-1:0] ClrLast  = RingAw'(RingSize - 1);
  localparam logic [7:0]        FillByte = 8'h20;

  // Length field plus MinMatch, minus one: index of the last copied byte
  localparam logic [4:0] LenBias = 5'(MinMatch - 1);

  // Request kinds on the input stream
  localparam logic [1:0] ReqData  = 2'd0;
  localparam logic [1:0] ReqStart = 2'd1;
  localparam logic [1:0] ReqEnd   = 2'd2;

  // Result kinds on the output stream
  localparam logic [1:0] StData     = 2'd0;
  localparam logic [1:0] StOverflow = 2'd1;
  localparam logic [1:0] StEnd      = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_COPY  = 3'b100
  } state_e;

  // Ring access request: one write port, one read port
  typedef struct packed {
    logic              we;
    logic [RingAw-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [RingAw-1:0] raddr;
  } ring_req_t;

endpackage

// ===== rtl/lzss_ring.sv =====
// ----------------------------------------------------------------------------
// lzss_ring
// History ring: single-port-write, single-port-read memory with a registered
// read and write-to-read forwarding for same-address accesses.
// ----------------------------------------------------------------------------
module lzss_ring
  import lzss_pkg::*;
(
  input  logic       clk_i,
  input  ring_req_t  req_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem [RingSize];
  logic [7:0] rdata_q;
  logic       fwd_q;
  logic [7:0] fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q    <= mem[req_i.raddr];
      // a write in the same cycle to the same entry wins
      fwd_q      <= req_i.we && (req_i.waddr == req_i.raddr);
      fwd_data_q <= req_i.wdata;
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

// ===== rtl/lzss_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// lzss_stream_decoder
// LZSS decompressor with a 4096-byte history ring, one compressed byte per
// request, one decompressed byte per result.
// ----------------------------------------------------------------------------
// Usage: after reset, and after every start request, the block sweeps the
// ring to spaces, one entry per cycle; s_axis_tready stays low during the
// sweep (configuration writes are still taken). A flag byte, a literal or
// the first byte of a pair is handled in the idle state. The second byte of
// a pair starts a copy: the controller enters the copy state, issues the
// first ring read, then emits one copied byte per cycle from the single ring
// read port, stretched by any output stall. An end request gives one result
// with the byte total. A new request is taken when the controller is idle and
// the output register is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
module lzss_stream_decoder
  import lzss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] code_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [31:8] total_count
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast,   // last_of_run
  // output limit register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_data_i
);

  // Controller state
  state_e            state_q, state_d;
  logic [RingAw-1:0] clr_q, clr_d;
  logic [RingAw-1:0] wpos_q, wpos_d;
  logic [7:0]        flag_q, flag_d;
  logic [3:0]        units_q, units_d;
  logic              phase_q, phase_d;
  logic [7:0]        offlow_q, offlow_d;
  logic [23:0]       count_q, count_d;
  logic              halted_q, halted_d;
  logic [23:0]       limit_q, limit_d;
  // Copy engine
  logic [RingAw-1:0] pos_q, pos_d;
  logic [4:0]        len_m1_q, len_m1_d;
  logic [4:0]        em_q, em_d;
  logic              rd_valid_q, rd_valid_d;
  // Output register
  logic              m_valid_q, m_valid_d;
  logic              m_load;
  logic [7:0]        m_byte_q, m_byte_d;
  logic [23:0]       m_count_q, m_count_d;
  logic [1:0]        m_status_q, m_status_d;
  logic              m_last_q, m_last_d;

  ring_req_t  ring_req;
  logic [7:0] ring_rdata;

  logic       out_free;
  logic       s_accept;
  logic       advance;
  logic       over;
  logic [4:0] em_next;
  logic       rd_en;

  lzss_ring u_ring (
    .clk_i  (clk_i),
    .req_i  (ring_req),
    .rdata_o(ring_rdata)
  );

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Emitting now would pass the limit
  assign over    = count_q >= limit_q;
  // Copy: take the pending ring byte when the output register can hold it
  assign advance = (state_q == ST_COPY) && rd_valid_q && out_free;
  assign em_next = em_q + {4'd0, advance};
  // Keep one read in flight ahead of the byte being emitted
  assign rd_en   = (state_q == ST_COPY) && (!rd_valid_q || advance) &&
                   (em_next <= len_m1_q) && !(advance && over);

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    wpos_d     = wpos_q;
    flag_d     = flag_q;
    units_d    = units_q;
    phase_d    = phase_q;
    offlow_d   = offlow_q;
    count_d    = count_q;
    halted_d   = halted_q;
    limit_d    = limit_q;
    pos_d      = pos_q;
    len_m1_d   = len_m1_q;
    em_d       = em_q;
    rd_valid_d = rd_valid_q;

    m_valid_d  = m_valid_q && !m_axis_tready;
    m_load     = 1'b0;
    m_byte_d   = 8'd0;
    m_count_d  = count_q;
    m_status_d = StData;
    m_last_d   = 1'b1;

    ring_req.we    = 1'b0;
    ring_req.waddr = wpos_q;
    ring_req.wdata = s_axis_tdata;
    ring_req.re    = rd_en;
    ring_req.raddr = pos_q + {7'd0, em_next};

    if (cfg_valid_i) begin
      limit_d = cfg_data_i;
    end

    unique case (state_q)
      ST_CLEAR: begin
        // sweep the ring to spaces
        ring_req.we    = 1'b1;
        ring_req.waddr = clr_q;
        ring_req.wdata = FillByte;
        clr_d          = clr_q + RingAw'(1);
        if (clr_q == ClrLast) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (s_accept) begin
          unique case (s_axis_tuser)
            ReqStart: begin
              wpos_d   = StartPos;
              flag_d   = 8'd0;
              units_d  = 4'd0;
              phase_d  = 1'b0;
              offlow_d = 8'd0;
              count_d  = 24'd0;
              halted_d = 1'b0;
              clr_d    = '0;
              state_d  = ST_CLEAR;
            end
            ReqEnd: begin
              // drop any half pair, next byte is a flag byte
              flag_d     = 8'd0;
              units_d    = 4'd0;
              phase_d    = 1'b0;
              m_load     = 1'b1;
              m_status_d = StEnd;
            end
            ReqData: begin
              if (!halted_q) begin
                if (units_q == 4'd0) begin
                  flag_d  = s_axis_tdata;
                  units_d = 4'd8;
                  phase_d = 1'b0;
                end else if (!phase_q) begin
                  if (flag_q[0]) begin
                    m_load = 1'b1;
                    if (over) begin
                      halted_d   = 1'b1;
                      m_status_d = StOverflow;
                    end else begin
                      ring_req.we = 1'b1;
                      wpos_d      = wpos_q + RingAw'(1);
                      count_d     = count_q + 24'd1;
                      m_byte_d    = s_axis_tdata;
                      m_count_d   = count_q + 24'd1;
                    end
                    flag_d  = {1'b0, flag_q[7:1]};
                    units_d = units_q - 4'd1;
                  end else begin
                    offlow_d = s_axis_tdata;
                    phase_d  = 1'b1;
                  end
                end else begin
                  // second pair byte: start the copy
                  pos_d      = {s_axis_tdata[7:4], offlow_q};
                  len_m1_d   = {1'b0, s_axis_tdata[3:0]} + LenBias;
                  em_d       = 5'd0;
                  rd_valid_d = 1'b0;
                  state_d    = ST_COPY;
                end
              end
            end
            default: begin
              // unknown request: drop
            end
          endcase
        end
      end

      ST_COPY: begin
        if (rd_en) begin
          rd_valid_d = 1'b1;
        end else if (advance) begin
          rd_valid_d = 1'b0;
        end
        if (advance) begin
          em_d   = em_next;
          m_load = 1'b1;
          if (over) begin
            halted_d   = 1'b1;
            m_status_d = StOverflow;
            rd_valid_d = 1'b0;
          end else begin
            ring_req.we    = 1'b1;
            ring_req.wdata = ring_rdata;
            wpos_d         = wpos_q + RingAw'(1);
            count_d        = count_q + 24'd1;
            m_byte_d       = ring_rdata;
            m_count_d      = count_q + 24'd1;
            m_last_d       = (em_q == len_m1_q);
          end
          if (over || (em_q == len_m1_q)) begin
            flag_d  = {1'b0, flag_q[7:1]};
            units_d = units_q - 4'd1;
            phase_d = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (m_load) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      wpos_q     <= StartPos;
      flag_q     <= 8'd0;
      units_q    <= 4'd0;
      phase_q    <= 1'b0;
      offlow_q   <= 8'd0;
      count_q    <= 24'd0;
      halted_q   <= 1'b0;
      limit_q    <= 24'hFFFFFF;
      pos_q      <= '0;
      len_m1_q   <= 5'd0;
      em_q       <= 5'd0;
      rd_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      wpos_q     <= wpos_d;
      flag_q     <= flag_d;
      units_q    <= units_d;
      phase_q    <= phase_d;
      offlow_q   <= offlow_d;
      count_q    <= count_d;
      halted_q   <= halted_d;
      limit_q    <= limit_d;
      pos_q      <= pos_d;
      len_m1_q   <= len_m1_d;
      em_q       <= em_d;
      rd_valid_q <= rd_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // Result payload: load on a new result, hold otherwise
  always_ff @(posedge clk_i) begin
    if (m_load) begin
      m_byte_q   <= m_byte_d;
      m_count_q  <= m_count_d;
      m_status_q <= m_status_d;
      m_last_q   <= m_last_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_count_q, m_byte_q};
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_last_q;

`ifndef SYNTH
  // A pending ring byte always belongs to the current match
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> (em_q <= len_m1_q))
    else $error("copy read ran past the match length");

  // Halting always comes with an overflow result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(halted_q) |-> (m_axis_tvalid && (m_axis_tuser == StOverflow) && m_axis_tlast))
    else $error("halt without overflow result");

  // No data byte beyond the output limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == StData)) |-> (m_axis_tdata[31:8] <= limit_q))
    else $error("data byte emitted beyond output limit");

  // A sweep cycle is never followed by a request taken in the copy state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |=> !(s_axis_tvalid && s_axis_tready && (state_q == ST_COPY)))
    else $error("copy started during ring sweep");
`endif

endmodule
